@@ rtl/core/fexp_pkg.sv @@
// ----------------------------------------------------------------------------
// fexp_pkg
// Types, coefficients and the integer exponent table of the Q9.23 exponential
// ----------------------------------------------------------------------------
package fexp_pkg;

   // field widths
   localparam int XW    = 32;   // argument, signed Q9.23
   localparam int FW    = 23;   // fraction bits
   localparam int EW    = 31;   // result magnitude
   localparam int AW    = 25;   // polynomial accumulator, holds values up to e
   localparam int TW    = 31;   // table entry width
   localparam int IW    = 5;    // table index width
   localparam int NSTEP = 4;    // horner steps
   localparam int PW    = FW + AW;        // horner product width
   localparam int QW    = AW + TW;        // final product width
   localparam int RW    = QW - FW;        // final product after the shift

   typedef logic signed [XW-1:0] x_type;
   typedef logic [EW-1:0]        exp_type;
   typedef logic [FW-1:0]        frac_type;
   typedef logic [AW-1:0]        acc_type;
   typedef logic [TW-1:0]        tab_type;
   typedef logic [IW-1:0]        idx_type;
   typedef logic [RW-1:0]        res_type;

   localparam int      K_MIN      = -16;
   localparam int      K_MAX      = 5;
   localparam idx_type TABLE_ZERO = idx_type'(16);
   localparam exp_type SAT_MAX    = exp_type'(2147483647);

   // horner coefficients, highest order first
   localparam acc_type COEF [0:NSTEP] = '{
      acc_type'(585781), acc_type'(1180076), acc_type'(4265307),
      acc_type'(8383615), acc_type'(8388241)
   };

   // e^k in Q9.23 for k from -16 to 5, index k + 16
   function automatic tab_type exp_int(input idx_type idx);
      tab_type val;
      unique case (idx)
         5'd0:    val = tab_type'(1);
         5'd1:    val = tab_type'(3);
         5'd2:    val = tab_type'(7);
         5'd3:    val = tab_type'(19);
         5'd4:    val = tab_type'(52);
         5'd5:    val = tab_type'(140);
         5'd6:    val = tab_type'(381);
         5'd7:    val = tab_type'(1035);
         5'd8:    val = tab_type'(2814);
         5'd9:    val = tab_type'(7649);
         5'd10:   val = tab_type'(20793);
         5'd11:   val = tab_type'(56522);
         5'd12:   val = tab_type'(153643);
         5'd13:   val = tab_type'(417644);
         5'd14:   val = tab_type'(1135275);
         5'd15:   val = tab_type'(3085996);
         5'd16:   val = tab_type'(8388608);
         5'd17:   val = tab_type'(22802601);
         5'd18:   val = tab_type'(61983895);
         5'd19:   val = tab_type'(168489696);
         5'd20:   val = tab_type'(458002478);
         5'd21:   val = tab_type'(1244979814);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/core/fixed_exponential.sv @@
// ----------------------------------------------------------------------------
// fixed_exponential
// A request passes the decode, horner and table multiply stages, then the output register.
// Throughput: one request per cycle unless the result side stalls; each horner
// step and the final table multiply own a pipeline stage, one multiplier each.
// A stall on the result side freezes the whole pipeline.
// Reset clears all stage valid bits and the output valid bit; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module fixed_exponential (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fexp_pkg::x_type   req_x_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fexp_pkg::exp_type rsp_exp_value,
   output logic              rsp_overflow,
   output logic              rsp_underflow
);
   import fexp_pkg::*;

   // stage registers: 0 decode, 1..4 horner, 5 table multiply
   logic     valid_ff [0:NSTEP+1];
   logic     valid_in [0:NSTEP+1];
   frac_type frac_ff  [0:NSTEP-1];
   frac_type frac_in  [0:NSTEP-1];
   acc_type  acc_ff   [0:NSTEP];
   acc_type  acc_in   [0:NSTEP];
   idx_type  idx_ff   [0:NSTEP];
   idx_type  idx_in   [0:NSTEP];
   logic     lo_ff    [0:NSTEP+1];
   logic     lo_in    [0:NSTEP+1];
   logic     hi_ff    [0:NSTEP+1];
   logic     hi_in    [0:NSTEP+1];
   res_type  res_ff;
   res_type  res_in;

   logic     rsp_valid_ff, rsp_valid_in;
   exp_type  rsp_exp_ff, rsp_exp_in;
   logic     rsp_ovf_ff, rsp_ovf_in;
   logic     rsp_unf_ff, rsp_unf_in;

   logic            advance;
   logic signed [8:0] k_int;
   logic [PW-1:0]   hprod [1:NSTEP];
   logic [AW:0]     hsum  [1:NSTEP];
   logic [QW-1:0]   fprod;

   // whole pipeline moves unless a result is held by the receiver
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // decode integer part and fraction
   assign k_int = req_x_value[XW-1:FW];

   always_comb begin
      valid_in[0] = req_valid;
      frac_in[0]  = req_x_value[FW-1:0];
      acc_in[0]   = COEF[0];
      idx_in[0]   = idx_type'(req_x_value[FW+IW-1:FW]) + TABLE_ZERO;
      lo_in[0]    = (k_int < 9'(K_MIN));
      hi_in[0]    = (k_int > 9'(K_MAX));

      // horner steps: acc = c + ((f * acc) >> 23)
      for (int j = 1; j <= NSTEP; j++) begin
         hprod[j]    = PW'(frac_ff[j-1]) * PW'(acc_ff[j-1]);
         hsum[j]     = (AW+1)'(COEF[j]) + (AW+1)'(hprod[j][PW-1:FW]);
         acc_in[j]   = hsum[j][AW-1:0];
         idx_in[j]   = idx_ff[j-1];
         valid_in[j] = valid_ff[j-1];
         lo_in[j]    = lo_ff[j-1];
         hi_in[j]    = hi_ff[j-1];
         if (j < NSTEP) frac_in[j] = frac_ff[j-1];
      end

      // scale by e^k
      fprod             = QW'(acc_ff[NSTEP]) * QW'(exp_int(idx_ff[NSTEP]));
      res_in            = fprod[QW-1:FW];
      valid_in[NSTEP+1] = valid_ff[NSTEP];
      lo_in[NSTEP+1]    = lo_ff[NSTEP];
      hi_in[NSTEP+1]    = hi_ff[NSTEP];
   end

   // saturation and special cases
   always_comb begin
      rsp_valid_in = valid_ff[NSTEP+1];
      rsp_unf_in   = lo_ff[NSTEP+1];
      rsp_ovf_in   = 1'b0;
      rsp_exp_in   = res_ff[EW-1:0];
      if (lo_ff[NSTEP+1]) begin
         rsp_exp_in = '0;
      end else if (hi_ff[NSTEP+1] || (res_ff > RW'(SAT_MAX))) begin
         rsp_exp_in = SAT_MAX;
         rsp_ovf_in = 1'b1;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NSTEP+1; j++) valid_ff[j] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int j = 0; j <= NSTEP+1; j++) valid_ff[j] <= valid_in[j];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < NSTEP; j++) frac_ff[j] <= frac_in[j];
         for (int j = 0; j <= NSTEP; j++) begin
            acc_ff[j] <= acc_in[j];
            idx_ff[j] <= idx_in[j];
         end
         for (int j = 0; j <= NSTEP+1; j++) begin
            lo_ff[j] <= lo_in[j];
            hi_ff[j] <= hi_in[j];
         end
         res_ff     <= res_in;
         rsp_exp_ff <= rsp_exp_in;
         rsp_ovf_ff <= rsp_ovf_in;
         rsp_unf_ff <= rsp_unf_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_exp_value = rsp_exp_ff;
   assign rsp_overflow  = rsp_ovf_ff;
   assign rsp_underflow = rsp_unf_ff;

   // flags are exclusive
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ovf_ff && rsp_unf_ff))
      else $error("overflow and underflow both set");

   // underflow forces zero
   a_unf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_unf_ff) |-> (rsp_exp_ff == '0))
      else $error("underflow with non-zero result");

   // overflow forces saturation
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_exp_ff == SAT_MAX))
      else $error("overflow without saturated result");

   // last stage reaches the output when the pipe moves
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NSTEP+1] && advance) |=> rsp_valid_ff)
      else $error("result lost at output register");

endmodule
